// ===== sv/sbv_pkg.sv =====
// shared constants, codes and payload types for the scrollback ring viewer
// no dependencies; imported by sbv_ram users and the top level
`default_nettype none

package sbv_pkg;

	localparam int SCREEN_LINES = 8;
	localparam int MAX_SCREENS  = 4;
	localparam int MIN_SCREENS  = 2;
	localparam int STORE_DEPTH  = SCREEN_LINES * MAX_SCREENS;

	localparam int PTR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
	localparam int LINE_W = (SCREEN_LINES > 1) ? $clog2(SCREEN_LINES) : 1;

	localparam int KIND_W = 3;
	localparam int MSG_W  = 32;
	localparam int SLOT_W = 3;
	localparam int CFG_W  = 3;

	// command kinds
	localparam logic [KIND_W-1:0] KIND_ADD         = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SCROLL_UP   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SCROLL_DOWN = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SCROLL_RST  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLEAR       = 3'd4;
	localparam logic [KIND_W-1:0] KIND_VIEW        = 3'd5;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [MSG_W-1:0]  message;
	} cmd_t;

	typedef struct packed {
		logic [MSG_W-1:0]  line_message;
		logic [SLOT_W-1:0] line_slot;
		logic              line_valid;
		logic              last_line;
	} line_t;

endpackage

`default_nettype wire

// ===== sv/sbv_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module sbv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/scrollback_ring_viewer.sv =====
// top level of the scrollback ring viewer: pointers, scroll control, view sequencer
// depends on sbv_pkg and sbv_ram
`default_nettype none

// Ring history of 32-bit message handles with a one-screen scrollable window.
// A command transfers on a rising edge with start high and busy low. Add,
// scroll up, scroll down, reset scroll and clear complete at that edge and
// busy stays low, so a new command can follow in the next cycle. A view read
// raises busy while it reads its visible lines (up to SCREEN_LINES = 8): the
// sequencer reads one history entry per cycle from the single read port of
// the history ram, and each line appears on the line port in the cycle after
// its read, for exactly one cycle, marked by line_strobe. The receiver cannot
// stall; every strobed cycle is a transfer. The last line of a view shows in
// the cycle busy drops. A view with no history gives a single line with
// line_valid low and last_line high in the cycle after the command, without
// raising busy. A write of screens_in_use resizes the ring and drops all
// history; the write is not gated by busy, so it must only be issued while idle
// with no line still to come.
module scrollback_ring_viewer (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire sbv_pkg::cmd_t               command,
	input  wire logic                        cfg_write_en,
	input  wire logic [sbv_pkg::CFG_W-1:0]   cfg_write_data,
	output logic                             line_strobe,
	output sbv_pkg::line_t                   line
);
	import sbv_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	// control state
	logic              state_q;
	logic [PTR_W-1:0]  newest_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  scroll_q;
	logic [CNT_W-1:0]  size_q;     // ring size, screen lines times screens in use

	// view sequencer
	logic [PTR_W-1:0]  pos_q;
	logic [LINE_W-1:0] idx_q;
	logic [LINE_W-1:0] lines_m1_q;

	// stage aligned with the ram read data
	logic              valid_s1;
	logic              empty_s1;
	logic              last_s1;
	logic [LINE_W-1:0] slot_s1;

	logic              accept;
	logic [MSG_W-1:0]  rdata;
	logic              ram_we;
	logic [PTR_W-1:0]  ram_waddr;
	logic [PTR_W-1:0]  add_ptr;
	logic [CNT_W-1:0]  newest_inc;
	logic [CNT_W-1:0]  pos_inc;
	logic [PTR_W-1:0]  pos_next;
	logic [CNT_W:0]    back;
	logic [CNT_W:0]    back_clip;
	logic [CNT_W:0]    wrap_sum;
	logic [CNT_W:0]    view_start;
	logic [LINE_W-1:0] view_lines_m1;
	logic [CFG_W-1:0]  screens_clamped;

	assign busy   = (state_q == ST_READ);
	assign accept = start && !busy;

	// next write slot for an add: position 0 on an empty ring, else wrap at ring size
	assign newest_inc = CNT_W'(newest_q) + CNT_W'(1);
	always_comb begin
		if (fill_q == '0) begin
			add_ptr = '0;
		end else if (newest_inc >= size_q) begin
			add_ptr = '0;
		end else begin
			add_ptr = newest_inc[PTR_W-1:0];
		end
	end

	assign ram_we    = accept && (command.kind == KIND_ADD);
	assign ram_waddr = add_ptr;

	// window start: lines back from the newest entry is one screen plus the scroll
	assign back      = (CNT_W+1)'(SCREEN_LINES) + {1'b0, scroll_q};
	assign back_clip = (back > {1'b0, size_q}) ? {1'b0, size_q} : back;
	assign wrap_sum  = (CNT_W+1)'(newest_inc) + {1'b0, size_q} - back_clip;
	always_comb begin
		if (fill_q < size_q) begin
			// ring not yet wrapped: oldest entry sits at position 0
			view_start = ({1'b0, fill_q} > back) ? ({1'b0, fill_q} - back) : '0;
		end else if (wrap_sum >= {1'b0, size_q}) begin
			view_start = wrap_sum - {1'b0, size_q};
		end else begin
			view_start = wrap_sum;
		end
	end

	// short history shows every entry, otherwise one full screen
	always_comb begin
		if (fill_q < CNT_W'(SCREEN_LINES)) begin
			view_lines_m1 = LINE_W'(fill_q - CNT_W'(1));
		end else begin
			view_lines_m1 = LINE_W'(SCREEN_LINES - 1);
		end
	end

	// sequencer read pointer walks round the ring
	assign pos_inc  = CNT_W'(pos_q) + CNT_W'(1);
	assign pos_next = (pos_inc >= size_q) ? '0 : pos_inc[PTR_W-1:0];

	// register writes below two screens or above the maximum are clamped
	always_comb begin
		if (cfg_write_data < CFG_W'(MIN_SCREENS)) begin
			screens_clamped = CFG_W'(MIN_SCREENS);
		end else if (cfg_write_data > CFG_W'(MAX_SCREENS)) begin
			screens_clamped = CFG_W'(MAX_SCREENS);
		end else begin
			screens_clamped = cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			newest_q   <= '0;
			fill_q     <= '0;
			scroll_q   <= '0;
			size_q     <= CNT_W'(SCREEN_LINES * MIN_SCREENS);
			pos_q      <= '0;
			idx_q      <= '0;
			lines_m1_q <= '0;
			valid_s1   <= 1'b0;
			empty_s1   <= 1'b0;
			last_s1    <= 1'b0;
			slot_s1    <= '0;
		end else begin
			valid_s1 <= 1'b0;
			if (cfg_write_en) begin
				// resize drops all history
				size_q   <= CNT_W'(SCREEN_LINES) * CNT_W'(screens_clamped);
				newest_q <= '0;
				fill_q   <= '0;
				scroll_q <= '0;
			end
			if (accept) begin
				case (command.kind)
					KIND_ADD: begin
						newest_q <= add_ptr;
						if (fill_q < size_q) begin
							fill_q <= fill_q + CNT_W'(1);
						end
					end
					KIND_SCROLL_UP: begin
						if (fill_q > CNT_W'(SCREEN_LINES) &&
							scroll_q < fill_q - CNT_W'(SCREEN_LINES)) begin
							scroll_q <= scroll_q + CNT_W'(1);
						end
					end
					KIND_SCROLL_DOWN: begin
						if (fill_q > CNT_W'(SCREEN_LINES) && scroll_q != '0) begin
							scroll_q <= scroll_q - CNT_W'(1);
						end
					end
					KIND_SCROLL_RST: begin
						scroll_q <= '0;
					end
					KIND_CLEAR: begin
						newest_q <= '0;
						fill_q   <= '0;
						scroll_q <= '0;
					end
					KIND_VIEW: begin
						if (fill_q == '0) begin
							// empty view: one invalid last line, no ram read
							valid_s1 <= 1'b1;
							empty_s1 <= 1'b1;
							last_s1  <= 1'b1;
							slot_s1  <= '0;
						end else begin
							state_q    <= ST_READ;
							pos_q      <= view_start[PTR_W-1:0];
							idx_q      <= '0;
							lines_m1_q <= view_lines_m1;
						end
					end
					default: begin
						// unused kinds are dropped
					end
				endcase
			end
			if (state_q == ST_READ) begin
				// one ram read per cycle, result shows next cycle
				valid_s1 <= 1'b1;
				empty_s1 <= 1'b0;
				slot_s1  <= idx_q;
				last_s1  <= (idx_q == lines_m1_q);
				pos_q    <= pos_next;
				idx_q    <= idx_q + LINE_W'(1);
				if (idx_q == lines_m1_q) begin
					state_q <= ST_IDLE;
				end
			end
		end
	end

	sbv_ram #(
		.WIDTH(MSG_W),
		.DEPTH(STORE_DEPTH)
	) u_history (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (command.message),
		.raddr  (pos_q),
		.rdata_q(rdata)
	);

	// result transfer
	assign line_strobe       = valid_s1;
	assign line.line_message = empty_s1 ? '0 : rdata;
	assign line.line_slot    = SLOT_W'(slot_s1);
	assign line.line_valid   = !empty_s1;
	assign line.last_line    = last_s1;

	// fill count never exceeds the ring size
	assert property (@(posedge clk) disable iff (!arst_n) fill_q <= size_q)
		else $error("fill count above ring size");

	// scroll offset stays inside the history beyond one screen
	assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q <= CNT_W'(SCREEN_LINES)) |-> (scroll_q == '0))
		else $error("scroll offset set with one screen or less of history");
	assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q > CNT_W'(SCREEN_LINES)) |-> (scroll_q <= fill_q - CNT_W'(SCREEN_LINES)))
		else $error("scroll offset beyond oldest screen");

	// history is never written while the sequencer reads it
	assert property (@(posedge clk) disable iff (!arst_n) ram_we |-> !busy)
		else $error("history write during view read");

	// read pointer stays inside the ring while reading
	assert property (@(posedge clk) disable iff (!arst_n) busy |-> (CNT_W'(pos_q) < size_q))
		else $error("view read pointer outside ring");

	// an invalid line only ever closes a view
	assert property (@(posedge clk) disable iff (!arst_n)
		(line_strobe && !line.line_valid) |-> line.last_line)
		else $error("invalid line that is not last");

endmodule

`default_nettype wire
